/* hdl/interrupt_distributor_regs_assert.svh */
// Assertion macros for the interrupt distributor register bank.
`ifndef INTERRUPT_DISTRIBUTOR_REGS_ASSERT_SVH
`define INTERRUPT_DISTRIBUTOR_REGS_ASSERT_SVH
`ifndef SYNTHESIS
// Checked on every rising edge while out of reset.
`define IDR_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("interrupt distributor assertion failed");
// Checked on every rising edge, reset included.
`define IDR_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("interrupt distributor assertion failed");
`else
`define IDR_ASSERT(label, clk, rst_n, prop)
`define IDR_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

/* hdl/idr_pkg.sv */
// Shared types and constants of the interrupt distributor register bank.
package idr_pkg;

    localparam int NUM_IRQS_DEFAULT = 256;
    localparam int NUM_SGIS         = 16;

    // Identification register fields
    localparam logic [7:0]  IIDR_PRODUCT        = 8'h19;
    localparam logic [11:0] IIDR_IMPLEMENTER    = 12'h43B;
    localparam logic [3:0]  ARCH_REVISION_RESET = 4'd3;

    // SGIs start out enabled and edge triggered (first row only)
    localparam logic [31:0] SGI_ROW_MASK = 32'((64'd1 << NUM_SGIS) - 64'd1);

    // Configuration port
    localparam int          APB_AW            = 3;
    localparam logic [0:0]  REG_ARCH_REVISION = 1'b0;

    typedef enum logic [1:0] {
        STATUS_DONE      = 2'd0,
        STATUS_READ_ONLY = 2'd1,
        STATUS_UNIMPL    = 2'd2,
        STATUS_UNHANDLED = 2'd3
    } status_t;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } ctrl_state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;  // latch the incoming transaction, start priority read
        logic commit;   // update state and load the result register
    } ctrl_cmd_t;

endpackage

/* hdl/idr_ctrl.sv */
// Controller: sequences capture and execute, owns the handshake flags.
module idr_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    output idr_pkg::ctrl_cmd_t cmd
);

    idr_pkg::ctrl_state_t state_reg, state_next;
    logic                 out_valid_reg, out_valid_next;

    // Output decode
    always_comb begin
        s_tready    = (state_reg == idr_pkg::ST_IDLE);
        cmd.capture = s_tvalid && (state_reg == idr_pkg::ST_IDLE);
        cmd.commit  = (state_reg == idr_pkg::ST_EXEC) && (!out_valid_reg || m_tready);
        m_tvalid    = out_valid_reg;
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            idr_pkg::ST_IDLE: begin
                if (cmd.capture) state_next = idr_pkg::ST_EXEC;
            end
            idr_pkg::ST_EXEC: begin
                if (cmd.commit) state_next = idr_pkg::ST_IDLE;
            end
            default: state_next = idr_pkg::ST_IDLE;
        endcase
    end

    // Result register occupancy
    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.commit)     out_valid_next = 1'b1;
        else if (m_tready)  out_valid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= idr_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

/* hdl/idr_datapath.sv */
// Datapath: request register, register map decode, interrupt state and result register.
module idr_datapath #(
    parameter int NUM_IRQS = idr_pkg::NUM_IRQS_DEFAULT
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  idr_pkg::ctrl_cmd_t cmd,
    input  logic [3:0]         arch_revision,
    input  logic [47:0]        s_tdata,
    input  logic [0:0]         s_tuser,
    output logic [95:0]        m_tdata,
    output logic [1:0]         m_tuser
);

    // NUM_IRQS is a multiple of 32: enable and edge state kept as 32-bit rows,
    // priorities as one 32-bit word per four IDs.
    localparam int EN_ROWS = NUM_IRQS / 32;
    localparam int EN_AW   = (EN_ROWS > 1) ? $clog2(EN_ROWS) : 1;
    localparam int PR_ROWS = NUM_IRQS / 4;
    localparam int PR_AW   = $clog2(PR_ROWS);

    typedef enum logic [3:0] {
        RG_CTLR, RG_IIDR, RG_TYPER2, RG_GROUP, RG_SENABLE, RG_CENABLE,
        RG_PENDACT, RG_PRIO, RG_CFG, RG_NONE
    } region_t;

    // Request register
    logic        req_wr_reg;
    logic [13:0] req_word_reg;
    logic [31:0] req_wdata_reg;

    // Interrupt state
    logic [31:0] en_rows_reg  [EN_ROWS];
    logic [31:0] edge_rows_reg[EN_ROWS];
    logic [31:0] prio_mem     [PR_ROWS];
    logic [PR_ROWS-1:0] prio_valid_reg;
    logic [31:0] prio_raw_reg;
    logic        prio_hit_reg;

    // Result register
    logic [31:0]      out_rd_reg, out_ne_reg, out_nd_reg;
    idr_pkg::status_t out_status_reg;

    // Incoming priority row lookup
    logic [13:0]      in_word;
    logic [PR_AW-1:0] in_prow;
    logic             in_prow_ok;

    assign in_word    = s_tdata[15:2];
    assign in_prow    = in_word[PR_AW-1:0];
    assign in_prow_ok = ({1'b0, in_word[7:0]} < 9'(PR_ROWS));

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            req_wr_reg    <= s_tuser[0];
            req_word_reg  <= in_word;
            req_wdata_reg <= s_tdata[47:16];
        end
        if (cmd.capture && in_prow_ok) begin
            prio_raw_reg <= prio_mem[in_prow];
        end
    end

    // Region decode on the word index
    region_t region;
    always_comb begin
        if (req_word_reg == 14'h000 || req_word_reg == 14'h001)      region = RG_CTLR;
        else if (req_word_reg == 14'h002)                            region = RG_IIDR;
        else if (req_word_reg == 14'h003)                            region = RG_TYPER2;
        else if (req_word_reg >= 14'h020 && req_word_reg < 14'h040)  region = RG_GROUP;
        else if (req_word_reg >= 14'h040 && req_word_reg < 14'h060)  region = RG_SENABLE;
        else if (req_word_reg >= 14'h060 && req_word_reg < 14'h080)  region = RG_CENABLE;
        else if (req_word_reg >= 14'h080 && req_word_reg < 14'h100)  region = RG_PENDACT;
        else if (req_word_reg >= 14'h100 && req_word_reg < 14'h1FF)  region = RG_PRIO;
        else if (req_word_reg >= 14'h300 && req_word_reg < 14'h340)  region = RG_CFG;
        else                                                         region = RG_NONE;
    end

    // Row selection
    logic [EN_AW-1:0] en_idx, ed_idx;
    logic             en_ok, ed_ok, half;
    logic [PR_AW-1:0] prow;
    logic             prow_ok;
    logic [31:0]      en_row, ed_row;
    logic [15:0]      ed_half;

    assign en_idx  = req_word_reg[EN_AW-1:0];
    assign en_ok   = ({1'b0, req_word_reg[4:0]} < 6'(EN_ROWS));
    assign ed_idx  = req_word_reg[EN_AW:1];
    assign ed_ok   = ({1'b0, req_word_reg[5:1]} < 6'(EN_ROWS));
    assign half    = req_word_reg[0];
    assign prow    = req_word_reg[PR_AW-1:0];
    assign prow_ok = ({1'b0, req_word_reg[7:0]} < 9'(PR_ROWS));
    assign en_row  = en_ok ? en_rows_reg[en_idx] : 32'h0;
    assign ed_row  = ed_ok ? edge_rows_reg[ed_idx] : 32'h0;
    assign ed_half = half ? ed_row[31:16] : ed_row[15:0];

    // Access execution
    logic [31:0]      rd_c, ne_c, nd_c, en_new, ed_new, cfg_rd;
    logic [15:0]      ed_half_new;
    idr_pkg::status_t st_c;
    logic             en_we, ed_we, pr_we;

    always_comb begin
        for (int i = 0; i < 16; i++) begin
            cfg_rd[2*i]     = 1'b0;
            cfg_rd[2*i + 1] = ed_half[i];
            ed_half_new[i]  = req_wdata_reg[2*i + 1];
        end
    end

    always_comb begin
        rd_c   = 32'h0;
        ne_c   = 32'h0;
        nd_c   = 32'h0;
        st_c   = idr_pkg::STATUS_DONE;
        en_we  = 1'b0;
        ed_we  = 1'b0;
        pr_we  = 1'b0;
        en_new = en_row;
        ed_new = half ? {ed_half_new, ed_row[15:0]} : {ed_row[31:16], ed_half_new};
        case (region)
            RG_CTLR: begin
                if (req_wr_reg) st_c = idr_pkg::STATUS_READ_ONLY;
            end
            RG_IIDR: begin
                if (req_wr_reg) st_c = idr_pkg::STATUS_READ_ONLY;
                else rd_c = {idr_pkg::IIDR_PRODUCT, 8'h00, arch_revision,
                             idr_pkg::IIDR_IMPLEMENTER};
            end
            RG_TYPER2: begin
                if (req_wr_reg) st_c = idr_pkg::STATUS_UNHANDLED;
            end
            RG_GROUP: begin
                // group bits are never written and stay zero
                if (req_wr_reg) st_c = idr_pkg::STATUS_READ_ONLY;
            end
            RG_SENABLE: begin
                if (req_wr_reg) begin
                    ne_c   = en_ok ? (req_wdata_reg & ~en_row) : 32'h0;
                    en_new = en_row | req_wdata_reg;
                    en_we  = en_ok;
                end else begin
                    rd_c = en_row;
                end
            end
            RG_CENABLE: begin
                if (req_wr_reg) begin
                    nd_c   = req_wdata_reg & en_row;
                    en_new = en_row & ~req_wdata_reg;
                    en_we  = en_ok;
                end else begin
                    rd_c = en_row;
                end
            end
            RG_PENDACT: begin
                if (req_wr_reg) st_c = idr_pkg::STATUS_UNIMPL;
            end
            RG_PRIO: begin
                if (req_wr_reg) pr_we = prow_ok;
                else if (prio_hit_reg) rd_c = prio_raw_reg;
            end
            RG_CFG: begin
                if (req_wr_reg) ed_we = ed_ok;
                else rd_c = cfg_rd;
            end
            RG_NONE: begin
                st_c = idr_pkg::STATUS_UNHANDLED;
            end
            default: begin
                st_c = idr_pkg::STATUS_UNHANDLED;
            end
        endcase
        if (req_wr_reg) rd_c = 32'h0;
    end

    // Enable and edge rows, priority valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int r = 0; r < EN_ROWS; r++) begin
                en_rows_reg[r]   <= (r == 0) ? idr_pkg::SGI_ROW_MASK : 32'h0;
                edge_rows_reg[r] <= (r == 0) ? idr_pkg::SGI_ROW_MASK : 32'h0;
            end
            prio_valid_reg <= '0;
            prio_hit_reg   <= 1'b0;
        end else begin
            if (cmd.commit && en_we) en_rows_reg[en_idx]   <= en_new;
            if (cmd.commit && ed_we) edge_rows_reg[ed_idx] <= ed_new;
            if (cmd.commit && pr_we) prio_valid_reg[prow]  <= 1'b1;
            if (cmd.capture) prio_hit_reg <= in_prow_ok && prio_valid_reg[in_prow];
        end
    end

    // Priority memory write port
    always_ff @(posedge aclk) begin
        if (cmd.commit && pr_we) prio_mem[prow] <= req_wdata_reg;
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            out_rd_reg     <= rd_c;
            out_ne_reg     <= ne_c;
            out_nd_reg     <= nd_c;
            out_status_reg <= st_c;
        end
    end

    assign m_tdata = {out_nd_reg, out_ne_reg, out_rd_reg};
    assign m_tuser = out_status_reg;

endmodule

/* hdl/interrupt_distributor_regs.sv */
// An accepted transaction executes in the execute state; its result is loaded into the
// result register when it is free; a waiting result delays execution until it is taken.
// No new transaction is accepted before the current one has executed: capture registers
// the request and the priority memory read, and the execute state follows.
// A waiting result does not block the next acceptance; only execution waits for it.
// Reset (aresetn, synchronous, active low) restores enables, edge bits,
// priority valid bits and the revision register at once; no clearing pass.
`include "interrupt_distributor_regs_assert.svh"
module interrupt_distributor_regs #(
    parameter int NUM_IRQS = idr_pkg::NUM_IRQS_DEFAULT
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [47:0]                s_tdata,   // byte_offset[15:0], write_data[47:16]
    input  logic [0:0]                 s_tuser,   // kind[0]
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [95:0]                m_tdata,   // read_data[31:0], newly_enabled[63:32],
                                                  // newly_disabled[95:64]
    output logic [1:0]                 m_tuser,   // status[1:0]
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [idr_pkg::APB_AW-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    idr_pkg::ctrl_cmd_t cmd;
    logic [3:0]         arch_rev_reg;
    logic               cfg_wr;

    // Configuration register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready &&
                    (paddr[2] == idr_pkg::REG_ARCH_REVISION);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            arch_rev_reg <= idr_pkg::ARCH_REVISION_RESET;
        end else if (cfg_wr) begin
            arch_rev_reg <= pwdata[3:0];
        end
    end

    assign prdata = (paddr[2] == idr_pkg::REG_ARCH_REVISION) ? {28'h0, arch_rev_reg} : 32'h0;

    idr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    idr_datapath #(
        .NUM_IRQS (NUM_IRQS)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .arch_revision (arch_rev_reg),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser)
    );

    // An enable word either sets or clears, never both
    `IDR_ASSERT(a_ne_nd_exclusive, aclk, aresetn, m_tvalid |-> (m_tdata[63:32] == 32'h0 || m_tdata[95:64] == 32'h0))
    // Ignored or failed accesses report no enable changes
    `IDR_ASSERT(a_status_no_change, aclk, aresetn, (m_tvalid && m_tuser != idr_pkg::STATUS_DONE) |-> (m_tdata[95:32] == 64'h0))
    // After an acceptance the block executes before taking another transaction
    `IDR_ASSERT(a_one_in_flight, aclk, aresetn, (s_tvalid && s_tready) |=> !s_tready)
    // Execution never overwrites a result that is still waiting
    `IDR_ASSERT_ALWAYS(a_no_overwrite, aclk, (cmd.commit && m_tvalid) |-> m_tready)

endmodule
